>>> rtl/core/bqbip_pkg.sv
package bqbip_pkg;

   // field widths
   localparam int WORD_W    = 64;
   localparam int IDX_W     = 6;
   localparam int INNER_W   = 16;
   localparam int ONES_W    = 13;
   localparam int BYTES     = WORD_W / 8;
   localparam int BCNT_W    = 4;
   localparam int WCNT_W    = 7;
   localparam int CONTRIB_W = 10;

   // index compare width, wide enough to hold the largest memory depth
   localparam int DEPTH_CMP_W = 11;

   localparam int DEF_MAX_WORDS = 64;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_BASE = 1'b1;

   // four query bit-plane words of one index
   typedef struct packed {
      logic [WORD_W-1:0] plane_three;
      logic [WORD_W-1:0] plane_two;
      logic [WORD_W-1:0] plane_one;
      logic [WORD_W-1:0] plane_zero;
   } planes_type;

   // control that travels with a base word down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

>>> rtl/core/bqbip_query_mem.sv
module bqbip_query_mem
   import bqbip_pkg::*;
#(
   parameter int MAX_WORDS = DEF_MAX_WORDS,
   parameter int ADDR_W    = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  planes_type        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output planes_type        rd_data
);

   planes_type query_mem_ff [MAX_WORDS];
   planes_type rd_data_ff;

   // plane word write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         query_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while no new read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= query_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bqbip_popcount.sv
module bqbip_popcount
   import bqbip_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  stage_ctl_type        ctl,
   input  logic                 in_range,
   input  logic [WORD_W-1:0]    base,
   input  planes_type           planes,
   output stage_ctl_type        ctl_out,
   output logic [CONTRIB_W-1:0] contrib,
   output logic [WCNT_W-1:0]    ones
);

   function automatic logic [BCNT_W-1:0] byte_ones(input logic [7:0] b);
      logic [BCNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {{(BCNT_W-1){1'b0}}, b[i]};
      end
      return n;
   endfunction

   function automatic logic [WCNT_W-1:0] sum_bytes(input logic [BYTES-1:0][BCNT_W-1:0] c);
      logic [WCNT_W-1:0] s;
      s = '0;
      for (int i = 0; i < BYTES; i++) begin
         s = s + {{(WCNT_W-BCNT_W){1'b0}}, c[i]};
      end
      return s;
   endfunction

   logic [4:0][WORD_W-1:0]              masked;
   logic [4:0][BYTES-1:0][BCNT_W-1:0]   bcnt_in, bcnt_ff;
   stage_ctl_type                       ctl_a_in, ctl_a_ff;
   logic [4:0][WCNT_W-1:0]              wcnt;
   logic [CONTRIB_W-1:0]                contrib_in, contrib_ff;
   logic [WCNT_W-1:0]                   ones_in, ones_ff;
   stage_ctl_type                       ctl_b_ff;

   // out-of-range index reads every plane as zero
   always_comb begin
      masked[0] = in_range ? (planes.plane_zero  & base) : '0;
      masked[1] = in_range ? (planes.plane_one   & base) : '0;
      masked[2] = in_range ? (planes.plane_two   & base) : '0;
      masked[3] = in_range ? (planes.plane_three & base) : '0;
      masked[4] = base;
      for (int w = 0; w < 5; w++) begin
         for (int k = 0; k < BYTES; k++) begin
            bcnt_in[w][k] = byte_ones(masked[w][k*8 +: 8]);
         end
      end
      ctl_a_in = ctl;
   end

   // first stage: per-byte counts
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (advance) begin
         ctl_a_ff <= ctl_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bcnt_ff <= bcnt_in;
      end
   end

   // word counts and plane weighting
   always_comb begin
      for (int w = 0; w < 5; w++) begin
         wcnt[w] = sum_bytes(bcnt_ff[w]);
      end
      contrib_in = {3'b000, wcnt[0]}
                 + {2'b00, wcnt[1], 1'b0}
                 + {1'b0, wcnt[2], 2'b00}
                 + {wcnt[3], 3'b000};
      ones_in = wcnt[4];
   end

   // second stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (advance) begin
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         contrib_ff <= contrib_in;
         ones_ff    <= ones_in;
      end
   end

   assign ctl_out = ctl_b_ff;
   assign contrib = contrib_ff;
   assign ones    = ones_ff;

endmodule

>>> rtl/core/bqbip_accum.sv
module bqbip_accum
   import bqbip_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  stage_ctl_type        ctl,
   input  logic [CONTRIB_W-1:0] contrib,
   input  logic [WCNT_W-1:0]    ones,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [INNER_W-1:0]   weighted_total,
   output logic [ONES_W-1:0]    ones_total
);

   logic [INNER_W-1:0] inner_acc_ff, inner_acc_in;
   logic [ONES_W-1:0]  ones_acc_ff, ones_acc_in;
   logic [INNER_W:0]   inner_sum;
   logic [ONES_W:0]    ones_sum;
   logic [INNER_W-1:0] inner_sat;
   logic [ONES_W-1:0]  ones_sat;
   logic               out_valid_ff, out_valid_in;
   logic [INNER_W-1:0] out_inner_ff, out_inner_in;
   logic [ONES_W-1:0]  out_ones_ff, out_ones_in;

   // saturating adds, the limits are all-ones so a carry means overflow
   always_comb begin
      inner_sum = {1'b0, inner_acc_ff} + {{(INNER_W+1-CONTRIB_W){1'b0}}, contrib};
      ones_sum  = {1'b0, ones_acc_ff} + {{(ONES_W+1-WCNT_W){1'b0}}, ones};
      inner_sat = inner_sum[INNER_W] ? '1 : inner_sum[INNER_W-1:0];
      ones_sat  = ones_sum[ONES_W] ? '1 : ones_sum[ONES_W-1:0];

      inner_acc_in = inner_acc_ff;
      ones_acc_in  = ones_acc_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_inner_in = out_inner_ff;
      out_ones_in  = out_ones_ff;

      if (advance && ctl.valid) begin
         if (ctl.last) begin
            inner_acc_in = '0;
            ones_acc_in  = '0;
            out_valid_in = 1'b1;
            out_inner_in = inner_sat;
            out_ones_in  = ones_sat;
         end else begin
            inner_acc_in = inner_sat;
            ones_acc_in  = ones_sat;
         end
      end
   end

   // accumulators and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_acc_ff <= '0;
         ones_acc_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         inner_acc_ff <= inner_acc_in;
         ones_acc_ff  <= ones_acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_inner_ff <= out_inner_in;
      out_ones_ff  <= out_ones_in;
   end

   assign rsp_tvalid     = out_valid_ff;
   assign weighted_total = out_inner_ff;
   assign ones_total     = out_ones_ff;

endmodule

>>> rtl/core/bitplane_query_binary_inner_product_core.sv
// takes one request per cycle unless stalled, load or base word; throughput is set
// by the single read port of the query plane memory, one entry per cycle
// a result is set on rsp_tvalid after the base stage, popcount stages and accumulator
// requests stall only while a finished result waits and another one reaches the output
// reset clears the pipeline valid bits, both accumulators and the output valid bit;
// the query plane memory is not cleared and holds garbage until loaded
module bitplane_query_binary_inner_product_core
   import bqbip_pkg::*;
#(
   parameter int MAX_WORDS = DEF_MAX_WORDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // word_index, plane_zero, plane_one, plane_two, plane_three, base_word, zero pad
   input  logic [327:0] req_tdata,
   // cmd
   input  logic [0:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // weighted_total, ones_total, zero pad
   output logic [31:0]  rsp_tdata
);

   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic                   advance;
   logic                   accept;
   logic [IDX_W-1:0]       word_index;
   planes_type             load_planes;
   logic [WORD_W-1:0]      base_word;
   logic [DEPTH_CMP_W-1:0] index_ext;
   logic                   in_range;
   logic [ADDR_W-1:0]      mem_addr;
   planes_type             rd_planes;
   stage_ctl_type          s1_ctl_in, s1_ctl_ff;
   logic                   s1_range_ff;
   logic [WORD_W-1:0]      s1_base_ff;
   stage_ctl_type          s3_ctl;
   logic [CONTRIB_W-1:0]   s3_contrib;
   logic [WCNT_W-1:0]      s3_ones;
   logic [INNER_W-1:0]     weighted_total;
   logic [ONES_W-1:0]      ones_total;

   // request unpacking
   assign word_index              = req_tdata[5:0];
   assign load_planes.plane_zero  = req_tdata[69:6];
   assign load_planes.plane_one   = req_tdata[133:70];
   assign load_planes.plane_two   = req_tdata[197:134];
   assign load_planes.plane_three = req_tdata[261:198];
   assign base_word               = req_tdata[325:262];

   // pipeline moves unless a finished result would collide with a waiting one
   assign advance    = !(s3_ctl.valid && s3_ctl.last && rsp_tvalid && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // index range check and memory address
   assign index_ext = {{(DEPTH_CMP_W-IDX_W){1'b0}}, word_index};
   assign in_range  = index_ext < DEPTH_CMP_W'(MAX_WORDS);
   assign mem_addr  = index_ext[ADDR_W-1:0];

   bqbip_query_mem #(
      .MAX_WORDS (MAX_WORDS),
      .ADDR_W    (ADDR_W)
   ) u_query_mem (
      .clock   (clock),
      .wr_en   (accept && (req_tuser[0] == CMD_LOAD) && in_range),
      .wr_addr (mem_addr),
      .wr_data (load_planes),
      .rd_en   (accept && (req_tuser[0] == CMD_BASE)),
      .rd_addr (mem_addr),
      .rd_data (rd_planes)
   );

   // base word stage alongside the memory read
   always_comb begin
      s1_ctl_in.valid = accept && (req_tuser[0] == CMD_BASE);
      s1_ctl_in.last  = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_range_ff <= in_range;
         s1_base_ff  <= base_word;
      end
   end

   bqbip_popcount u_popcount (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl      (s1_ctl_ff),
      .in_range (s1_range_ff),
      .base     (s1_base_ff),
      .planes   (rd_planes),
      .ctl_out  (s3_ctl),
      .contrib  (s3_contrib),
      .ones     (s3_ones)
   );

   bqbip_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .ctl            (s3_ctl),
      .contrib        (s3_contrib),
      .ones           (s3_ones),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .weighted_total (weighted_total),
      .ones_total     (ones_total)
   );

   // response packing
   assign rsp_tdata = {3'b000, ones_total, weighted_total};

endmodule

>>> tb/sv/inner_product_checker.sv
`timescale 1ns / 1ps

module inner_product_checker
   import bqbip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // word_index, plane_zero, plane_one, plane_two, plane_three, base_word, zero pad
   input  logic [327:0] req_tdata,
   // cmd
   input  logic [0:0]   req_tuser,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // weighted_total, ones_total, zero pad
   input  logic [31:0]  rsp_tdata,
   output int           errors,
   output int           pending,
   output int           sums_checked,
   output int           saturated_sums
);

   localparam int INNER_LIMIT = 2**INNER_W - 1;
   localparam int ONES_LIMIT  = 2**ONES_W - 1;

   typedef struct packed {
      logic [INNER_W-1:0] weighted_total;
      logic [ONES_W-1:0]  ones_total;
   } sums_type;

   // own copy of the query plane memory and the two running sums
   planes_type query_planes [2**IDX_W];
   int         inner_sum;
   int         ones_sum;
   sums_type   expected_sums [$];

   always @(posedge clock) begin
      planes_type        req_planes;
      planes_type        stored;
      logic [WORD_W-1:0] base;
      logic [IDX_W-1:0]  index;
      sums_type          got;
      sums_type          want;
      int                contrib;
      int                fails;
      int                checked;
      int                saturated;

      fails     = 0;
      checked   = 0;
      saturated = 0;
      if (reset) begin
         inner_sum = 0;
         ones_sum  = 0;
         expected_sums.delete();
      end else begin
         // compare each accepted result with the oldest expected sums
         if (rsp_tvalid && rsp_tready) begin
            got.weighted_total = rsp_tdata[INNER_W-1:0];
            got.ones_total     = rsp_tdata[INNER_W +: ONES_W];
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d / %0d",
                        $time, got.weighted_total, got.ones_total);
               fails++;
            end else begin
               want = expected_sums.pop_front();
               checked++;
               if (got.weighted_total !== want.weighted_total) begin
                  $display("%0t: weighted_total mismatch, expected %0d, actual %0d",
                           $time, want.weighted_total, got.weighted_total);
                  fails++;
               end
               if (got.ones_total !== want.ones_total) begin
                  $display("%0t: ones_total mismatch, expected %0d, actual %0d",
                           $time, want.ones_total, got.ones_total);
                  fails++;
               end
            end
         end

         // predict from each accepted request
         if (req_tvalid && req_tready) begin
            index      = req_tdata[IDX_W-1:0];
            req_planes = req_tdata[IDX_W +: 4*WORD_W];
            base       = req_tdata[IDX_W+4*WORD_W +: WORD_W];
            if (req_tuser[0] == CMD_LOAD) begin
               query_planes[index] = req_planes;
            end else begin
               stored  = query_planes[index];
               contrib = $countones(stored.plane_zero & base)
                       + 2 * $countones(stored.plane_one & base)
                       + 4 * $countones(stored.plane_two & base)
                       + 8 * $countones(stored.plane_three & base);
               inner_sum = inner_sum + contrib;
               if (inner_sum > INNER_LIMIT) begin
                  inner_sum = INNER_LIMIT;
               end
               ones_sum = ones_sum + $countones(base);
               if (ones_sum > ONES_LIMIT) begin
                  ones_sum = ONES_LIMIT;
               end
               // last base word closes the vector and clears both sums
               if (req_tlast) begin
                  want.weighted_total = INNER_W'(inner_sum);
                  want.ones_total     = ONES_W'(ones_sum);
                  expected_sums.push_back(want);
                  if (inner_sum == INNER_LIMIT || ones_sum == ONES_LIMIT) begin
                     saturated++;
                  end
                  inner_sum = 0;
                  ones_sum  = 0;
               end
            end
         end
      end

      errors         <= errors + fails;
      sums_checked   <= sums_checked + checked;
      saturated_sums <= saturated_sums + saturated;
      pending        <= expected_sums.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bqbip_pkg::*;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [327:0] req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;

   int sum_errors;
   int sums_pending;
   int sums_checked;
   int saturated_sums;

   // idle percentages of both sides and the receiver hold-off bookkeeping
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int holdoff_asks = 0;
   int holdoff_done = 0;
   int holdoff_left = 0;

   int               requests_sent = 0;
   int               loads_sent    = 0;
   int               bases_sent    = 0;
   bit               query_loaded [2**IDX_W];
   logic [IDX_W-1:0] loaded_indexes [$];

   bitplane_query_binary_inner_product_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   inner_product_checker sums_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .errors         (sum_errors),
      .pending        (sums_pending),
      .sums_checked   (sums_checked),
      .saturated_sums (saturated_sums)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver ready, with random stalls and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_done != holdoff_asks) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= 200;
         holdoff_done <= holdoff_asks;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // random word, biased toward zero, all ones and sparse patterns
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic planes_type rand_planes();
      planes_type p;
      p.plane_zero  = rand_word();
      p.plane_one   = rand_word();
      p.plane_two   = rand_word();
      p.plane_three = rand_word();
      return p;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(logic cmd, logic [IDX_W-1:0] index, planes_type planes,
                               logic [WORD_W-1:0] base, logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= last;
      req_tdata  <= {2'b00, base, planes, index};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (cmd == CMD_LOAD) begin
         loads_sent++;
         if (!query_loaded[index]) begin
            query_loaded[index] = 1'b1;
            loaded_indexes.push_back(index);
         end
      end else begin
         bases_sent++;
      end
   endtask

   // load carries random base and last bits, both unused
   task automatic load_query(logic [IDX_W-1:0] index, planes_type planes);
      send_request(CMD_LOAD, index, planes, rand_word(), 1'($urandom_range(1)));
   endtask

   // base word carries random plane bits, unused
   task automatic push_base(logic [IDX_W-1:0] index, logic [WORD_W-1:0] base, logic last);
      send_request(CMD_BASE, index, rand_planes(), base, last);
   endtask

   // one vector of base words over loaded indexes, sometimes with a load in between
   task automatic send_vector(int words);
      logic [IDX_W-1:0] index;
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(7) == 0) begin
            load_query(IDX_W'($urandom_range(2**IDX_W - 1)), rand_planes());
         end
         index = loaded_indexes[$urandom_range(loaded_indexes.size() - 1)];
         push_base(index, rand_word(), i == words - 1);
      end
   endtask

   task automatic random_traffic(int count);
      int stop_at;
      int n;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         if ($urandom_range(9) < 2) begin
            n = $urandom_range(3, 1);
            repeat (n) load_query(IDX_W'($urandom_range(2**IDX_W - 1)), rand_planes());
         end else if ($urandom_range(4) == 0) begin
            send_vector($urandom_range(24, 5));
         end else begin
            send_vector($urandom_range(4, 1));
         end
      end
   endtask

   // sender goes quiet until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sums_pending != 0);
   endtask

   initial begin
      planes_type weights;
      planes_type top_plane;

      weights.plane_zero    = 64'h0000_0000_0000_0001;
      weights.plane_one     = 64'h0000_0000_0000_0003;
      weights.plane_two     = 64'h0000_0000_0000_000F;
      weights.plane_three   = 64'h0000_0000_0000_00FF;
      top_plane.plane_zero  = '0;
      top_plane.plane_one   = '0;
      top_plane.plane_two   = '0;
      top_plane.plane_three = 64'h8000_0000_0000_0000;

      tx_idle_pct = 35;
      rx_idle_pct = 69;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, plane weights, last on load, mid-vector load
      send_request(CMD_LOAD, 0, '0, '1, 1'b1);
      send_request(CMD_LOAD, 63, '1, '0, 1'b0);
      send_request(CMD_LOAD, 1, weights, '0, 1'b0);
      send_request(CMD_LOAD, 2, top_plane, '1, 1'b1);
      push_base(0, '1, 1'b1);
      push_base(63, '1, 1'b1);
      push_base(63, '0, 1'b1);
      push_base(1, '1, 1'b1);
      push_base(2, '1, 1'b1);
      push_base(1, '1, 1'b0);
      load_query(3, rand_planes());
      push_base(63, {$urandom, $urandom}, 1'b0);
      push_base(3, {$urandom, $urandom}, 1'b1);
      push_base(2, 64'h8000_0000_0000_0001, 1'b1);

      // phase one: sender idles less than the receiver
      random_traffic(95);

      // receiver holds off while short vectors keep coming
      holdoff_asks <= holdoff_asks + 1;
      repeat (30) send_vector(1);
      wait_drained();

      // phase two: roles swapped
      tx_idle_pct = 69;
      rx_idle_pct = 35;
      random_traffic(95);
      wait_drained();

      // phase three: no idling, overlong vector saturates both sums
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_query(63, '1);
      for (int i = 0; i < 135; i++) begin
         push_base(63, '1, i == 134);
      end
      random_traffic(80);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d requests: %0d query loads and %0d base words",
               requests_sent, loads_sent, bases_sent);
      $display("compared %0d sums, %0d of them saturated, after %0d receiver hold-off",
               sums_checked, saturated_sums, holdoff_asks);
      if (sum_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
